[hdl/ffca_pkg.sv]
package ffca_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_NULL      = 3'd2,
    ST_NOT_ALLOC = 3'd3,
    ST_FULL      = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // request passed down the chain, registered in each cell
  typedef struct packed {
    logic        active;
    logic        mode;
    logic [63:0] key;
    logic [31:0] size;
    logic [31:0] stamp;
  } req_t;

  // best candidate handed from cell to cell
  typedef struct packed {
    logic        found;
    logic [11:0] idx;
    logic [31:0] age;
    logic [31:0] bytes;
    logic [63:0] base;
  } cand_t;

endpackage

[hdl/first_fit_chunk_allocator.sv]
// Each request walks the chain of chunk cells one cell per cycle, then a commit state and
// the output beat; a new request is taken only after the previous result beat is accepted.
// Zero size and free of null skip the chain: result beat in the cycle after the input beat.
// Reset (rst, synchronous, active high) empties the table and clears heap state.
module first_fit_chunk_allocator #(
  parameter int MAX_CHUNKS = 64,
  parameter int HEADER_BYTES = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [31:0] req_size,
  input  logic [31:0] user_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_addr,
  output logic [31:0] granted_size,
  output logic [2:0]  status
);

  localparam int IDX_BITS = $clog2(MAX_CHUNKS);
  localparam int CNT_BITS = $clog2(MAX_CHUNKS + 1);
  localparam int GROW_BITS = (ADDR_BITS > 32 ? ADDR_BITS : 32) + 1;
  localparam logic [GROW_BITS-1:0] ADDR_MAX = GROW_BITS'({1'b0, {ADDR_BITS{1'b1}}});

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DONE = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  logic [31:0] heap_base;
  logic [ADDR_BITS-1:0] heap_top;
  logic heap_started;
  logic [CNT_BITS-1:0] chunk_count;
  logic [31:0] free_counter;
  logic [CNT_BITS-1:0] scan_cnt;
  logic        r_mode;
  logic [31:0] r_size;

  ffca_pkg::req_t  req_chain  [MAX_CHUNKS+1];
  ffca_pkg::cand_t cand_chain [MAX_CHUNKS+1];
  logic [MAX_CHUNKS-1:0] wr_new, set_free, clr_free;

  logic [ADDR_BITS-1:0] top_eff;
  logic [GROW_BITS-1:0] grow;
  ffca_pkg::cand_t      fin;
  logic                 launch;

  assign in_ready = (state == S_IDLE);
  assign launch   = in_valid && in_ready;
  assign fin      = cand_chain[MAX_CHUNKS];
  assign top_eff  = heap_started ? heap_top : ADDR_BITS'(heap_base);
  assign grow     = GROW_BITS'(r_size) + GROW_BITS'(HEADER_BYTES);

  always_comb begin
    req_chain[0].active = launch && !(mode == ffca_pkg::MODE_ALLOC ? req_size == '0
                                                                   : user_addr == '0);
    req_chain[0].mode   = mode;
    req_chain[0].key    = 64'(user_addr);
    req_chain[0].size   = req_size;
    req_chain[0].stamp  = free_counter;
    cand_chain[0]       = '0;
  end

  genvar g;
  generate
    for (g = 0; g < MAX_CHUNKS; g++) begin : g_cell
      ffca_cell #(
        .ADDR_BITS(ADDR_BITS), .HEADER_BYTES(HEADER_BYTES), .MY_IDX(g)
      ) u_cell (
        .clk(clk), .rst(rst),
        .req_in(req_chain[g]), .cand_in(cand_chain[g]),
        .in_range(CNT_BITS'(g) < chunk_count),
        .wr_new(wr_new[g]), .wr_base(top_eff), .wr_bytes(r_size),
        .set_free(set_free[g]), .clr_free(clr_free[g]), .wr_stamp(free_counter),
        .req_out(req_chain[g+1]), .cand_out(cand_chain[g+1])
      );
    end
  endgenerate

  logic commit_new;
  always_comb begin
    wr_new = '0;
    set_free = '0;
    clr_free = '0;
    commit_new = 1'b0;
    if (state == S_DONE && r_mode == ffca_pkg::MODE_ALLOC && r_size != '0) begin
      if (fin.found) begin
        clr_free[fin.idx[IDX_BITS-1:0]] = 1'b1;
      end else if (chunk_count < CNT_BITS'(MAX_CHUNKS) &&
                   !(grow > ADDR_MAX || GROW_BITS'(top_eff) > ADDR_MAX - grow)) begin
        commit_new = 1'b1;
        wr_new[chunk_count[IDX_BITS-1:0]] = 1'b1;
      end
    end
    if (state == S_DONE && r_mode == ffca_pkg::MODE_FREE && fin.found) begin
      set_free[fin.idx[IDX_BITS-1:0]] = 1'b1;
    end
  end

  logic [ADDR_BITS-1:0] new_user;
  assign new_user = top_eff + ADDR_BITS'(HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      heap_base    <= '0;
      heap_top     <= '0;
      heap_started <= 1'b0;
      chunk_count  <= '0;
      free_counter <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) heap_base <= cfg_wdata;
      case (state)
        S_IDLE: begin
          if (launch) begin
            r_mode   <= mode;
            r_size   <= req_size;
            scan_cnt <= '0;
            if (mode == ffca_pkg::MODE_FREE && user_addr == '0) begin
              status <= ffca_pkg::ST_NULL; result_addr <= '0; granted_size <= '0;
              out_valid <= 1'b1; state <= S_OUT;
            end else if (mode == ffca_pkg::MODE_ALLOC && req_size == '0) begin
              status <= ffca_pkg::ST_ZERO; result_addr <= '0; granted_size <= '0;
              out_valid <= 1'b1; state <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // wait for the request to reach the end of the chain
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == CNT_BITS'(MAX_CHUNKS - 2)) state <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state     <= S_OUT;
          if (r_mode == ffca_pkg::MODE_FREE) begin
            result_addr <= '0;
            if (fin.found) begin
              granted_size <= fin.bytes;
              status       <= ffca_pkg::ST_OK;
              free_counter <= free_counter + 1'b1;
            end else begin
              granted_size <= '0;
              status       <= ffca_pkg::ST_NOT_ALLOC;
            end
          end else begin
            heap_started <= 1'b1;
            if (!heap_started && !commit_new) heap_top <= ADDR_BITS'(heap_base);
            if (fin.found) begin
              result_addr  <= 32'(fin.base[ADDR_BITS-1:0] + ADDR_BITS'(HEADER_BYTES));
              granted_size <= fin.bytes;
              status       <= ffca_pkg::ST_OK;
            end else if (chunk_count >= CNT_BITS'(MAX_CHUNKS)) begin
              result_addr  <= '0;
              granted_size <= '0;
              status       <= ffca_pkg::ST_FULL;
            end else if (!commit_new) begin
              result_addr  <= '0;
              granted_size <= '0;
              status       <= ffca_pkg::ST_OVERFLOW;
            end else begin
              result_addr  <= 32'(new_user);
              granted_size <= r_size;
              status       <= ffca_pkg::ST_OK;
              chunk_count  <= chunk_count + 1'b1;
              heap_top     <= top_eff + grow[ADDR_BITS-1:0];
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/ffca_cell.sv]
module ffca_cell #(
  parameter int ADDR_BITS = 32,
  parameter int HEADER_BYTES = 16,
  parameter int MY_IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  ffca_pkg::req_t  req_in,
  input  ffca_pkg::cand_t cand_in,
  input  logic            in_range,
  input  logic            wr_new,
  input  logic [ADDR_BITS-1:0] wr_base,
  input  logic [31:0]     wr_bytes,
  input  logic            set_free,
  input  logic            clr_free,
  input  logic [31:0]     wr_stamp,
  output ffca_pkg::req_t  req_out,
  output ffca_pkg::cand_t cand_out
);

  logic [ADDR_BITS-1:0] base;
  logic [31:0]          bytes;
  logic [31:0]          order;
  logic                 is_free;
  logic [ADDR_BITS-1:0] user;
  logic [31:0]          age;
  logic                 hit;
  ffca_pkg::cand_t      cand_next;

  assign user = base + ADDR_BITS'(HEADER_BYTES);
  assign age  = req_in.stamp - order;

  always_comb begin
    cand_next = cand_in;
    hit = 1'b0;
    if (req_in.active && in_range) begin
      if (req_in.mode == ffca_pkg::MODE_ALLOC) begin
        hit = is_free && (bytes >= req_in.size) && (!cand_in.found || age < cand_in.age);
      end else begin
        hit = !is_free && !cand_in.found && (user == req_in.key[ADDR_BITS-1:0]);
      end
    end
    if (hit) begin
      cand_next.found = 1'b1;
      cand_next.idx   = 12'(MY_IDX);
      cand_next.age   = age;
      cand_next.bytes = bytes;
      cand_next.base  = 64'(base);
    end
  end

  always_ff @(posedge clk) begin
    cand_out <= cand_next;
    if (rst) begin
      is_free <= 1'b0;
      req_out <= '0;
    end else begin
      req_out <= req_in;
      if (wr_new) begin
        base    <= wr_base;
        bytes   <= wr_bytes;
        order   <= '0;
        is_free <= 1'b0;
      end else if (set_free) begin
        is_free <= 1'b1;
        order   <= wr_stamp;
      end else if (clr_free) begin
        is_free <= 1'b0;
      end
    end
  end

endmodule

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCHUNK = 64;
  localparam int HDR = 16;
  localparam logic [63:0] AMASK = 64'h0000_0000_FFFF_FFFF;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        mode;
  logic [31:0] req_size;
  logic [31:0] user_addr;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] result_addr;
  logic [31:0] granted_size;
  logic [2:0]  status;

  first_fit_chunk_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .req_size(req_size), .user_addr(user_addr),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_addr(result_addr), .granted_size(granted_size), .status(status)
  );

  typedef struct {
    logic [31:0]       addr;
    logic [31:0]       size;
    ffca_pkg::status_t st;
  } grant_t;

  typedef struct {
    logic              m;
    logic [31:0]       sz;
    logic [31:0]       ad;
    bit                typed;
    logic [31:0]       e_addr;
    logic [31:0]       e_size;
    ffca_pkg::status_t e_st;
  } stim_row_t;

  // allocator shadow state
  logic [63:0] sh_base [NCHUNK];
  logic [31:0] sh_bytes [NCHUNK];
  bit          sh_free [NCHUNK];
  logic [31:0] sh_order [NCHUNK];
  int          sh_count;
  logic [31:0] sh_free_ctr;
  logic [63:0] sh_top;
  bit          sh_started;
  logic [31:0] sh_heap_base;

  grant_t pending_grants[$];
  int     fail_cnt;
  int     beats_in, beats_out;
  int     n_status [6];
  int     in_idle_pct, out_idle_pct;
  bit     hold_req;
  bit     hold_seen;
  int     hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("timeout with %0d results outstanding", pending_grants.size());
    $display("** first_fit_chunk_allocator: FAILED **");
    $finish;
  end

  function automatic logic [31:0] user_of(int i);
    return 32'((sh_base[i] + 64'(HDR)) & AMASK);
  endfunction

  function automatic grant_t predict_grant(logic m, logic [31:0] sz, logic [31:0] ad);
    grant_t g;
    bit found;
    int pick;
    logic [31:0] best_age, age;
    logic [63:0] grow;
    g = '{32'd0, 32'd0, ffca_pkg::ST_OK};
    found = 0;
    pick = 0;
    best_age = '0;
    if (m == ffca_pkg::MODE_ALLOC) begin
      if (sz == 0) begin
        g.st = ffca_pkg::ST_ZERO;
        return g;
      end
      if (!sh_started) begin
        sh_top = 64'(sh_heap_base) & AMASK;
        sh_started = 1;
      end
      for (int i = 0; i < sh_count; i++) begin
        if (!sh_free[i] || sh_bytes[i] < sz) continue;
        age = sh_free_ctr - sh_order[i];
        if (!found || age < best_age) begin
          found = 1;
          best_age = age;
          pick = i;
        end
      end
      if (found) begin
        sh_free[pick] = 0;
        g.addr = user_of(pick);
        g.size = sh_bytes[pick];
        return g;
      end
      if (sh_count >= NCHUNK) begin
        g.st = ffca_pkg::ST_FULL;
        return g;
      end
      grow = 64'(sz) + 64'(HDR);
      if (grow > AMASK || sh_top > AMASK - grow) begin
        g.st = ffca_pkg::ST_OVERFLOW;
        return g;
      end
      sh_base[sh_count] = sh_top;
      sh_bytes[sh_count] = sz;
      sh_free[sh_count] = 0;
      sh_order[sh_count] = '0;
      g.addr = user_of(sh_count);
      g.size = sz;
      sh_count++;
      sh_top = (sh_top + grow) & AMASK;
      return g;
    end
    if (ad == 0) begin
      g.st = ffca_pkg::ST_NULL;
      return g;
    end
    for (int i = 0; i < sh_count; i++) begin
      if (sh_free[i] || user_of(i) != ad) continue;
      sh_free[i] = 1;
      sh_order[i] = sh_free_ctr;
      sh_free_ctr = sh_free_ctr + 1;
      g.size = sh_bytes[i];
      return g;
    end
    g.st = ffca_pkg::ST_NOT_ALLOC;
    return g;
  endfunction

  task automatic send_req(stim_row_t r);
    grant_t g;
    @(negedge clk);
    in_valid  <= 1'b1;
    mode      <= r.m;
    req_size  <= r.sz;
    user_addr <= r.ad;
    do @(posedge clk); while (!in_ready);
    g = predict_grant(r.m, r.sz, r.ad);
    if (r.typed) g = '{r.e_addr, r.e_size, r.e_st};
    pending_grants.push_back(g);
    beats_in++;
    if ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(6)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_heap_base(logic [31:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sh_heap_base = v;
  endtask

  function automatic stim_row_t random_row();
    stim_row_t r;
    logic [31:0] live[$], dead[$];
    int k;
    r = '{ffca_pkg::MODE_ALLOC, 32'd0, 32'd0, 0, 32'd0, 32'd0, ffca_pkg::ST_OK};
    r.ad = $urandom;
    k = $urandom_range(99);
    if ($urandom_range(99) < 55) begin
      if (k < 80) r.sz = $urandom_range(128, 1);
      else if (k < 88) r.sz = 32'd0;
      else if (k < 95) r.sz = $urandom;
      else r.sz = $urandom_range(4096, 129);
    end else begin
      r.m = ffca_pkg::MODE_FREE;
      r.sz = $urandom;
      for (int i = 0; i < sh_count; i++) begin
        if (sh_free[i]) dead.push_back(user_of(i));
        else live.push_back(user_of(i));
      end
      if (k < 70 && live.size() != 0) r.ad = live[$urandom_range(live.size() - 1)];
      else if (k < 80 && dead.size() != 0) r.ad = dead[$urandom_range(dead.size() - 1)];
      else if (k >= 90) r.ad = 32'd0;
    end
    return r;
  endfunction

  // receiver: random stalls plus a single long hold-off
  always @(negedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_left = 400;
      hold_seen = 1;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    grant_t e;
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (pending_grants.size() == 0) begin
        $error("result beat with nothing expected");
        fail_cnt++;
      end else begin
        e = pending_grants.pop_front();
        if (result_addr !== e.addr) begin
          $error("result_addr: expected %h, got %h", e.addr, result_addr);
          fail_cnt++;
        end
        if (granted_size !== e.size) begin
          $error("granted_size: expected %h, got %h", e.size, granted_size);
          fail_cnt++;
        end
        if (status !== 3'(e.st)) begin
          $error("status: expected %0d, got %0d", e.st, status);
          fail_cnt++;
        end
        if (e.st <= ffca_pkg::ST_OVERFLOW) n_status[int'(e.st)]++;
      end
    end
  end

  stim_row_t pre_heap [4] = '{
    '{ffca_pkg::MODE_ALLOC, 32'd0, 32'd0, 1, 32'd0, 32'd0, ffca_pkg::ST_ZERO},
    '{ffca_pkg::MODE_FREE, 32'hFFFF_FFFF, 32'd0, 1, 32'd0, 32'd0, ffca_pkg::ST_NULL},
    '{ffca_pkg::MODE_FREE, 32'd0, 32'hFFFF_FFFF, 1, 32'd0, 32'd0, ffca_pkg::ST_NOT_ALLOC},
    '{ffca_pkg::MODE_FREE, 32'd5, 32'h0000_0010, 1, 32'd0, 32'd0, ffca_pkg::ST_NOT_ALLOC}
  };

  // heap starts at 0x1000 for these rows
  stim_row_t heap_rows [16] = '{
    '{ffca_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 32'd0, 1, 32'd0, 32'd0, ffca_pkg::ST_OVERFLOW},
    '{ffca_pkg::MODE_ALLOC, 32'hFFFF_EFF0, 32'd0, 1, 32'd0, 32'd0, ffca_pkg::ST_OVERFLOW},
    '{ffca_pkg::MODE_ALLOC, 32'd16, 32'd0, 1, 32'h1010, 32'd16, ffca_pkg::ST_OK},
    '{ffca_pkg::MODE_ALLOC, 32'd1, 32'd0, 0, 32'd0, 32'd0, ffca_pkg::ST_OK},
    '{ffca_pkg::MODE_ALLOC, 32'd100, 32'd0, 0, 32'd0, 32'd0, ffca_pkg::ST_OK},
    '{ffca_pkg::MODE_FREE, 32'd0, 32'h1010, 0, 32'd0, 32'd0, ffca_pkg::ST_OK},
    '{ffca_pkg::MODE_FREE, 32'd0, 32'h1010, 1, 32'd0, 32'd0, ffca_pkg::ST_NOT_ALLOC},
    '{ffca_pkg::MODE_ALLOC, 32'd8, 32'd0, 0, 32'd0, 32'd0, ffca_pkg::ST_OK},
    '{ffca_pkg::MODE_FREE, 32'd0, 32'h1030, 0, 32'd0, 32'd0, ffca_pkg::ST_OK},
    '{ffca_pkg::MODE_FREE, 32'd0, 32'h1041, 0, 32'd0, 32'd0, ffca_pkg::ST_OK},
    '{ffca_pkg::MODE_ALLOC, 32'd1, 32'd0, 0, 32'd0, 32'd0, ffca_pkg::ST_OK},
    '{ffca_pkg::MODE_ALLOC, 32'd1, 32'd0, 0, 32'd0, 32'd0, ffca_pkg::ST_OK},
    '{ffca_pkg::MODE_FREE, 32'd0, 32'h1030, 0, 32'd0, 32'd0, ffca_pkg::ST_OK},
    '{ffca_pkg::MODE_ALLOC, 32'd2, 32'd0, 0, 32'd0, 32'd0, ffca_pkg::ST_OK},
    '{ffca_pkg::MODE_FREE, 32'd0, 32'hFFFF_FFFF, 1, 32'd0, 32'd0, ffca_pkg::ST_NOT_ALLOC},
    '{ffca_pkg::MODE_ALLOC, 32'h8000_0000, 32'd0, 0, 32'd0, 32'd0, ffca_pkg::ST_OK}
  };

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    mode = ffca_pkg::MODE_ALLOC;
    req_size = '0;
    user_addr = '0;
    hold_req = 0;
    fail_cnt = 0;
    beats_in = 0;
    beats_out = 0;
    foreach (n_status[i]) n_status[i] = 0;
    for (int i = 0; i < NCHUNK; i++) begin
      sh_base[i] = '0;
      sh_bytes[i] = '0;
      sh_free[i] = 0;
      sh_order[i] = '0;
    end
    sh_count = 0;
    sh_free_ctr = '0;
    sh_top = '0;
    sh_started = 0;
    sh_heap_base = '0;
    in_idle_pct = 31;
    out_idle_pct = 58;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_heap_base(32'hFFFF_FFFF);
    foreach (pre_heap[i]) send_req(pre_heap[i]);
    drain();
    write_heap_base(32'h0000_1000);
    foreach (heap_rows[i]) send_req(heap_rows[i]);

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: write_heap_base(32'h0000_0000);
        1: begin
          write_heap_base($urandom);
          in_idle_pct = 58;
          out_idle_pct = 31;
        end
        default: begin
          write_heap_base(32'hFFFF_FFFF);
          in_idle_pct = 0;
          out_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < 180; n++) begin
        // stall the output while requests keep coming
        if (ph == 0 && n == 60) hold_req = 1;
        send_req(random_row());
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("%0d requests sent, %0d results checked, %0d chunks carved, %0d frees",
             beats_in, beats_out, sh_count, sh_free_ctr);
    $display("status mix ok/zero/null/unalloc/full/overflow: %0d/%0d/%0d/%0d/%0d/%0d",
             n_status[0], n_status[1], n_status[2], n_status[3], n_status[4], n_status[5]);
    if (fail_cnt == 0) begin
      $display("** first_fit_chunk_allocator: PASSED **");
    end else begin
      $display("** first_fit_chunk_allocator: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/ffca_pkg.sv
hdl/ffca_cell.sv
hdl/first_fit_chunk_allocator.sv
tb/sv/tb.sv
